// ----- rtl/i32div_pkg.sv -----
// shared types and constants for the 32-bit signed/unsigned divider
// no dependencies; imported by the controller, datapath and top level
`timescale 1ns / 1ps

package i32div_pkg;

  localparam int unsigned DefaultDataWidth = 32;

  typedef enum logic [1:0] {
    ACT_UDIV = 2'd0,
    ACT_UREM = 2'd1,
    ACT_SDIV = 2'd2,
    ACT_SREM = 2'd3
  } action_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic fix;
  } cmd_t;

endpackage

// ----- rtl/i32div_ctrl.sv -----
// controller state machine: sequences load, one step per quotient bit, sign fix-up
// depends on i32div_pkg
`timescale 1ns / 1ps

module i32div_ctrl import i32div_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DefaultDataWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic done_o,
  output cmd_t cmd_o
);

  localparam int unsigned CntW = $clog2(DATA_WIDTH);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_FIX  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic accept;

  // a new transaction may start while the previous result is strobed
  assign busy   = (state_q == ST_CALC) || (state_q == ST_FIX);
  assign accept = start && !busy;
  assign done_o = (state_q == ST_DONE);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    cmd_o.fix  = 1'b0;
    case (state_q)
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          cnt_d      = CntW'(DATA_WIDTH - 1);
          state_d    = ST_CALC;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CALC: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = ST_DONE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/i32div_dpath.sv -----
// datapath: operand magnitudes, restoring shift/subtract step, sign fix-up
// depends on i32div_pkg
`timescale 1ns / 1ps

module i32div_dpath import i32div_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DefaultDataWidth
) (
  input  logic                  clk_i,
  input  cmd_t                  cmd_i,
  input  logic [1:0]            action_i,
  input  logic [DATA_WIDTH-1:0] dividend_i,
  input  logic [DATA_WIDTH-1:0] divisor_i,
  output logic [DATA_WIDTH-1:0] result_o
);

  localparam int unsigned W = DATA_WIDTH;

  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] quo_q, quo_d;  // holds remaining dividend bits, then the quotient
  logic [W-1:0] dsr_q, dsr_d;
  logic         neg_q, neg_d;
  logic         sel_rem_q, sel_rem_d;
  logic [W-1:0] res_q, res_d;

  action_e      act;
  logic         is_signed;
  logic         n_neg, d_neg;
  logic [W-1:0] n_mag, d_mag;
  logic [W-1:0] rem_sh;
  logic [W:0]   diff;
  logic         take;
  logic [W-1:0] pick;

  assign act       = action_e'(action_i);
  assign is_signed = act inside {ACT_SDIV, ACT_SREM};
  assign n_neg     = is_signed && dividend_i[W-1];
  assign d_neg     = is_signed && divisor_i[W-1];
  assign n_mag     = n_neg ? (~dividend_i + 1'b1) : dividend_i;
  assign d_mag     = d_neg ? (~divisor_i + 1'b1) : divisor_i;

  // the bit shifted out of the partial remainder acts as a carry into the compare
  assign rem_sh = {rem_q[W-2:0], quo_q[W-1]};
  assign diff   = {rem_q[W-1], rem_sh} - {1'b0, dsr_q};
  assign take   = !diff[W];

  assign pick = sel_rem_q ? rem_q : quo_q;

  always_comb begin
    rem_d     = rem_q;
    quo_d     = quo_q;
    dsr_d     = dsr_q;
    neg_d     = neg_q;
    sel_rem_d = sel_rem_q;
    res_d     = res_q;
    if (cmd_i.load) begin
      rem_d     = '0;
      quo_d     = n_mag;
      dsr_d     = d_mag;
      sel_rem_d = act inside {ACT_UREM, ACT_SREM};
      neg_d     = (act inside {ACT_UREM, ACT_SREM}) ? n_neg : (n_neg ^ d_neg);
    end
    if (cmd_i.step) begin
      rem_d = take ? diff[W-1:0] : rem_sh;
      quo_d = {quo_q[W-2:0], take};
    end
    if (cmd_i.fix) begin
      res_d = neg_q ? (~pick + 1'b1) : pick;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    dsr_q     <= dsr_d;
    neg_q     <= neg_d;
    sel_rem_q <= sel_rem_d;
    res_q     <= res_d;
  end

  assign result_o = res_q;

endmodule

// ----- rtl/int32_divider_signed_unsigned_unit.sv -----
// top level of the signed/unsigned integer divider
// depends on i32div_pkg, i32div_ctrl, i32div_dpath
`timescale 1ns / 1ps

// usage:
//   drive action_i, dividend_i, divisor_i and raise start; the transaction is
//   taken at the rising edge where start is high and busy is low
//   action_i: 0 unsigned quotient, 1 unsigned remainder,
//             2 signed quotient, 3 signed remainder (truncating toward zero)
//   the result appears on result_o with done_o high for exactly one cycle;
//   the operands are loaded at the accepting edge, then follow DATA_WIDTH
//   restoring steps (one quotient bit each, through a single shared
//   subtractor), a sign fix-up step that registers result_o, and the
//   done_o cycle
//   busy is low again in the done_o cycle, so a new transaction can be taken
//   there; before that, busy is high and no new transaction is taken
//   divide by zero gives all ones (quotient; 1 for a negative signed dividend) or the dividend (remainder)
//   the receiver cannot stall: result_o is valid only while done_o is high
//   reset (rst_ni low, asynchronous) returns the controller to idle and
//   drops any transaction in flight; no result is strobed for it
module int32_divider_signed_unsigned_unit import i32div_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DefaultDataWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            action_i,
  input  logic [DATA_WIDTH-1:0] dividend_i,
  input  logic [DATA_WIDTH-1:0] divisor_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] result_o
);

  cmd_t cmd;

  i32div_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .done_o(done_o),
    .cmd_o (cmd)
  );

  i32div_dpath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dpath (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .action_i  (action_i),
    .dividend_i(dividend_i),
    .divisor_i (divisor_i),
    .result_o  (result_o)
  );

endmodule

// ----- rtl/i32div_checker.sv -----
// port-level checker for the divider top level, attached by bind
// depends on int32_divider_signed_unsigned_unit
`timescale 1ns / 1ps

module i32div_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // an accepted transaction keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // the result strobe lasts one cycle only
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o held longer than one cycle");

  // the unit is ready again while the result is strobed
  a_done_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("busy high during result strobe");

  // no result right after an accepted transaction
  a_no_early_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !done_o)
    else $error("result strobed too early");

endmodule

bind int32_divider_signed_unsigned_unit i32div_checker u_i32div_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o)
);

// ----- sim/tb.sv -----
// self-checking testbench for int32_divider_signed_unsigned_unit
// depends on i32div_pkg and the divider rtl; directed table first, then random transactions
`timescale 1ns / 1ps

module tb;
  import i32div_pkg::*;

  localparam int unsigned Width = DefaultDataWidth;
  localparam logic [Width-1:0] AllOnes = '1;
  localparam logic [Width-1:0] MinNeg = {1'b1, {(Width-1){1'b0}}};
  localparam logic [Width-1:0] MaxPos = {1'b0, {(Width-1){1'b1}}};
  localparam int RandomCount = 1100;
  localparam int MaxReports = 10;

  typedef struct {
    action_e          act;
    logic [Width-1:0] dividend;
    logic [Width-1:0] divisor;
    logic             has_value;
    logic [Width-1:0] value;
  } div_vector_t;

  typedef struct {
    action_e          act;
    logic [Width-1:0] dividend;
    logic [Width-1:0] divisor;
    logic [Width-1:0] value;
  } div_expect_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [1:0]       action_i;
  logic [Width-1:0] dividend_i;
  logic [Width-1:0] divisor_i;
  logic             done_o;
  logic [Width-1:0] result_o;

  div_vector_t directed_rows[$];
  div_expect_t expected_results[$];
  int          fail_count = 0;
  int          checked_count = 0;
  int          action_count[4] = '{0, 0, 0, 0};
  int          zero_divisor_count = 0;

  int32_divider_signed_unsigned_unit #(
    .DATA_WIDTH(Width)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .action_i  (action_i),
    .dividend_i(dividend_i),
    .divisor_i (divisor_i),
    .done_o    (done_o),
    .result_o  (result_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // restoring division, the carry holds the bit shifted out of the partial remainder
  function automatic void restoring_divide(input logic [Width-1:0] n, input logic [Width-1:0] d,
                                           output logic [Width-1:0] q,
                                           output logic [Width-1:0] r);
    logic carry;
    q = '0;
    r = '0;
    if (d == '0) begin
      q = AllOnes;
      r = n;
      return;
    end
    for (int i = Width - 1; i >= 0; i--) begin
      carry = r[Width-1];
      r = {r[Width-2:0], n[i]};
      if (carry || r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
  endfunction

  function automatic logic [Width-1:0] predict_result(action_e act, logic [Width-1:0] n,
                                                      logic [Width-1:0] d);
    logic             n_neg;
    logic             d_neg;
    logic [Width-1:0] q;
    logic [Width-1:0] r;
    n_neg = n[Width-1];
    d_neg = d[Width-1];
    case (act)
      ACT_UDIV: begin
        restoring_divide(n, d, q, r);
        return q;
      end
      ACT_UREM: begin
        restoring_divide(n, d, q, r);
        return r;
      end
      ACT_SDIV: begin
        restoring_divide(n_neg ? -n : n, d_neg ? -d : d, q, r);
        return (n_neg != d_neg) ? -q : q;
      end
      default: begin
        restoring_divide(n_neg ? -n : n, d_neg ? -d : d, q, r);
        return n_neg ? -r : r;
      end
    endcase
  endfunction

  function automatic logic [Width-1:0] random_operand(bit rare_zero);
    int pick;
    pick = $urandom_range(0, 15);
    if (rare_zero && pick == 0) pick = $urandom_range(1, 15);
    case (pick)
      0:       return '0;
      1:       return 1;
      2:       return AllOnes;
      3:       return MinNeg;
      4:       return MaxPos;
      5:       return $urandom_range(0, 255);
      6:       return -$urandom_range(1, 255);
      7, 8:    return $urandom >> $urandom_range(0, Width - 1);
      9:       return -($urandom >> $urandom_range(0, Width - 1));
      default: return $urandom;
    endcase
  endfunction

  // idle cycles before the next transaction: mostly none or short, a few long
  function automatic int random_gap(int index);
    int pick;
    if ((index / 64) % 3 == 0) return 0;
    pick = $urandom_range(0, 9);
    if (pick < 5) return 0;
    if (pick < 9) return $urandom_range(1, 40);
    return $urandom_range(41, 200);
  endfunction

  task automatic report_failure(string msg);
    fail_count++;
    if (fail_count <= MaxReports) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic add_row(action_e act, logic [Width-1:0] n, logic [Width-1:0] d,
                         logic has_value, logic [Width-1:0] value);
    div_vector_t row;
    row.act = act;
    row.dividend = n;
    row.divisor = d;
    row.has_value = has_value;
    row.value = value;
    directed_rows.push_back(row);
  endtask

  // entered right after a rising edge; returns right after the accepting edge
  task automatic send_transaction(div_vector_t row, int gap);
    div_expect_t entry;
    @(negedge clk_i);
    if (gap > 0) begin
      start      <= 1'b0;
      action_i   <= 2'($urandom_range(0, 3));
      dividend_i <= $urandom;
      divisor_i  <= $urandom;
      repeat (gap) @(negedge clk_i);
    end
    start      <= 1'b1;
    action_i   <= row.act;
    dividend_i <= row.dividend;
    divisor_i  <= row.divisor;
    do @(posedge clk_i); while (busy);
    entry.act = row.act;
    entry.dividend = row.dividend;
    entry.divisor = row.divisor;
    entry.value = row.has_value ? row.value
                                : predict_result(row.act, row.dividend, row.divisor);
    expected_results.push_back(entry);
    action_count[row.act]++;
    if (row.divisor == '0) zero_divisor_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    div_expect_t entry;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report_failure($sformatf("result %h with no transaction outstanding", result_o));
      end else begin
        entry = expected_results.pop_front();
        checked_count++;
        if (result_o !== entry.value) begin
          report_failure($sformatf("%s %h / %h: expected %h, got %h", entry.act.name(),
                                   entry.dividend, entry.divisor, entry.value, result_o));
        end
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    div_vector_t row;
    rst_ni     = 1'b0;
    start      = 1'b0;
    action_i   = '0;
    dividend_i = '0;
    divisor_i  = '0;

    // divide by zero
    add_row(ACT_UDIV, '0, '0, 1'b1, AllOnes);
    add_row(ACT_UREM, 32'h1234_5678, '0, 1'b1, 32'h1234_5678);
    add_row(ACT_SDIV, MinNeg, '0, 1'b1, 1);
    add_row(ACT_SDIV, 5, '0, 1'b1, AllOnes);
    add_row(ACT_SREM, MinNeg, '0, 1'b1, MinNeg);
    // most negative operand
    add_row(ACT_SDIV, MinNeg, AllOnes, 1'b1, MinNeg);
    add_row(ACT_SREM, MinNeg, AllOnes, 1'b1, '0);
    add_row(ACT_SDIV, MinNeg, 2, 1'b1, 32'hC000_0000);
    add_row(ACT_SDIV, MaxPos, MinNeg, 1'b1, '0);
    add_row(ACT_SREM, MaxPos, MinNeg, 1'b1, MaxPos);
    // unsigned extremes
    add_row(ACT_UDIV, AllOnes, 1, 1'b1, AllOnes);
    add_row(ACT_UREM, AllOnes, 1, 1'b1, '0);
    add_row(ACT_UDIV, AllOnes, AllOnes, 1'b1, 1);
    add_row(ACT_UDIV, '0, AllOnes, 1'b1, '0);
    add_row(ACT_UDIV, 32'hFFFF_FFFE, AllOnes, 1'b1, '0);
    add_row(ACT_UREM, 32'hFFFF_FFFE, AllOnes, 1'b1, 32'hFFFF_FFFE);
    // carry out of the partial remainder
    add_row(ACT_UDIV, AllOnes, 32'h8000_0001, 1'b1, 1);
    add_row(ACT_UREM, AllOnes, 32'h8000_0001, 1'b1, 32'h7FFF_FFFE);
    // truncation toward zero and sign rules
    add_row(ACT_SDIV, -7, 2, 1'b1, -3);
    add_row(ACT_SREM, -7, 2, 1'b1, -1);
    add_row(ACT_SDIV, 7, -2, 1'b1, -3);
    add_row(ACT_SREM, 7, -2, 1'b1, 1);
    add_row(ACT_SDIV, -7, -2, 1'b1, 3);
    add_row(ACT_SREM, -7, -2, 1'b1, -1);
    add_row(ACT_UREM, 32'hDEAD_BEEF, 32'h0001_2345, 1'b0, '0);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_transaction(directed_rows[i], random_gap(i + 64));

    for (int k = 0; k < RandomCount; k++) begin
      row.act = action_e'($urandom_range(0, 3));
      row.dividend = random_operand(1'b0);
      row.divisor = random_operand(1'b1);
      row.has_value = 1'b0;
      row.value = '0;
      send_transaction(row, random_gap(k));
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (Width + 4) @(posedge clk_i);

    $display("checked %0d results: udiv %0d, urem %0d, sdiv %0d, srem %0d",
             checked_count, action_count[ACT_UDIV], action_count[ACT_UREM],
             action_count[ACT_SDIV], action_count[ACT_SREM]);
    $display("%0d transactions with a zero divisor, %0d mismatches", zero_divisor_count,
             fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
